// ===== rtl/core/light_bar_pair_scorer_defines.svh =====
// Assertion macros for the light bar pair scorer.
// Used by files that carry concurrent assertions; needs clk and rst_n in scope.
`ifndef LIGHT_BAR_PAIR_SCORER_DEFINES_SVH
`define LIGHT_BAR_PAIR_SCORER_DEFINES_SVH

// Same-cycle implication, off while reset is held.
`define LBPS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, off while reset is held.
`define LBPS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/core/lbps_pkg.sv =====
// Shared types, constants and helper functions of the light bar pair scorer.
// No dependencies; imported by lbps_cordic and the top level.
package lbps_pkg;

  localparam logic [13:0] HALF_TURN    = 14'd11520;
  localparam logic [13:0] QUARTER_TURN = 14'd5760;
  localparam logic [23:0] DEV_SAT      = 24'hFF_FFFF;
  localparam logic [17:0] BAD_SAT      = 18'h3_FFFF;
  localparam logic signed [24:0] Z_MAX = 25'sd5898240;

  typedef enum logic [2:0] {
    CAUSE_NONE     = 3'd0,
    CAUSE_SIZE     = 3'd1,
    CAUSE_PARALLEL = 3'd2,
    CAUSE_ASPECT   = 3'd3,
    CAUSE_LINK     = 3'd4
  } cause_t;

  typedef enum logic [2:0] {
    REG_MAX_AREA_RATIO_DEV = 3'd0,
    REG_MAX_SIDE_RATIO_DEV = 3'd1,
    REG_MAX_PARALLEL_ERROR = 3'd2,
    REG_MAX_LINK_MISS      = 3'd3,
    REG_MIN_PLATE_ASPECT   = 3'd4,
    REG_MAX_PLATE_ASPECT   = 3'd5,
    REG_LARGE_PLATE_ASPECT = 3'd6,
    REG_HEIGHT_SCALE       = 3'd7
  } cfg_idx_t;

  typedef enum logic [2:0] {
    LINK_ZERO,
    LINK_HALF,
    LINK_QUARTER,
    LINK_DIRECT,
    LINK_MIRROR
  } link_case_t;

  // Rotation angle of each CORDIC step in 2^-16 degree.
  function automatic logic signed [24:0] atan_step(input int unsigned i);
    case (i)
      0:       return 25'sd2949120;
      1:       return 25'sd1740967;
      2:       return 25'sd919879;
      3:       return 25'sd466945;
      4:       return 25'sd234379;
      5:       return 25'sd117304;
      6:       return 25'sd58666;
      7:       return 25'sd29335;
      8:       return 25'sd14668;
      9:       return 25'sd7334;
      10:      return 25'sd3667;
      11:      return 25'sd1833;
      12:      return 25'sd917;
      13:      return 25'sd458;
      14:      return 25'sd229;
      15:      return 25'sd115;
      default: return 25'sd0;
    endcase
  endfunction

  // Shift that rounds towards zero for either sign.
  function automatic logic signed [25:0] shr_sym(input logic signed [25:0] v,
                                                 input int unsigned n);
    logic signed [25:0] m;
    m = v[25] ? -v : v;
    m = m >>> n;
    return v[25] ? -m : m;
  endfunction

  // Bar angle with a quarter turn added for tall rectangles, wrapped to a half turn.
  function automatic logic [13:0] real_angle(input logic [15:0] w, input logic [15:0] h,
                                             input logic signed [13:0] raw);
    logic signed [15:0] a;
    a = 16'(raw);
    if (h > w) begin
      a = a + $signed({2'b00, QUARTER_TURN});
    end
    if (a < 0) begin
      a = a + $signed({2'b00, HALF_TURN});
    end else if (a >= $signed({2'b00, HALF_TURN})) begin
      a = a - $signed({2'b00, HALF_TURN});
    end
    return a[13:0];
  endfunction

endpackage

// ===== rtl/core/lbps_dly.sv =====
// Fixed-length delay line that keeps side data aligned with the arithmetic units.
// Depends on nothing; advances with the pipeline enable.
module lbps_dly #(
  parameter int unsigned W = 8,
  parameter int unsigned N = 2
) (
  input  logic         clk,
  input  logic         en,
  input  logic [W-1:0] din,
  output logic [W-1:0] dout
);

  logic [W-1:0] stage_r [0:N-1];

  always_ff @(posedge clk) begin
    if (en) begin
      stage_r[0] <= din;
    end
  end

  for (genvar k = 1; k < N; k++) begin : g_tap
    always_ff @(posedge clk) begin
      if (en) begin
        stage_r[k] <= stage_r[k-1];
      end
    end
  end

  assign dout = stage_r[N-1];

endmodule

// ===== rtl/core/lbps_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, flagging overflow and division by zero.
// Depends on nothing; an input register stage precedes the quotient bit stages.
module lbps_div #(
  parameter int unsigned NW = 40,
  parameter int unsigned DW = 32,
  parameter int unsigned QW = 25
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo,
  output logic          sat
);

  localparam int unsigned HW = NW - QW;

  logic [DW-1:0] rem_r [0:QW-1];
  logic [QW-1:0] low_r [0:QW-1];
  logic [DW-1:0] den_r [0:QW-1];
  logic [QW-1:0] quo_r [0:QW];
  logic          sat_r [0:QW];
  logic [HW-1:0] hi;

  assign hi = num[NW-1:QW];

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= DW'(hi);
      low_r[0] <= num[QW-1:0];
      den_r[0] <= den;
      quo_r[0] <= '0;
      sat_r[0] <= (den == '0) || (DW'(hi) >= den);
    end
  end

  for (genvar k = 1; k <= QW; k++) begin : g_bit
    logic [DW:0]   trial;
    logic [DW:0]   diff;
    logic          ge;
    logic [DW-1:0] rem_nxt;

    assign trial   = {rem_r[k-1], low_r[k-1][QW-1]};
    assign diff    = trial - {1'b0, den_r[k-1]};
    assign ge      = trial >= {1'b0, den_r[k-1]};
    assign rem_nxt = ge ? diff[DW-1:0] : trial[DW-1:0];

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[k] <= {quo_r[k-1][QW-2:0], ge};
        sat_r[k] <= sat_r[k-1];
      end
    end

    if (k < QW) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[k] <= rem_nxt;
          low_r[k] <= low_r[k-1] << 1;
          den_r[k] <= den_r[k-1];
        end
      end
    end
  end

  assign quo = quo_r[QW];
  assign sat = sat_r[QW];

endmodule

// ===== rtl/core/lbps_isqrt.sv =====
// Pipelined integer square root of the summed squared centre offsets.
// Depends on nothing; one root bit per stage.
module lbps_isqrt (
  input  logic        clk,
  input  logic        en,
  input  logic [31:0] sq_a,
  input  logic [31:0] sq_b,
  output logic [16:0] root
);

  localparam int unsigned VW = 34;
  localparam int unsigned RW = 17;

  logic [VW-1:0] v_r    [0:RW];
  logic [RW+1:0] rem_r  [0:RW];
  logic [RW-1:0] root_r [0:RW];

  always_ff @(posedge clk) begin
    if (en) begin
      v_r[0]    <= VW'(sq_a) + VW'(sq_b);
      rem_r[0]  <= '0;
      root_r[0] <= '0;
    end
  end

  for (genvar k = 1; k <= RW; k++) begin : g_step
    logic [RW+3:0] tr;
    logic [RW+3:0] trial;
    logic [RW+3:0] diff;
    logic          ge;

    assign tr    = {rem_r[k-1], v_r[k-1][VW-1:VW-2]};
    assign trial = (RW+4)'({root_r[k-1], 2'b01});
    assign diff  = tr - trial;
    assign ge    = tr >= trial;

    always_ff @(posedge clk) begin
      if (en) begin
        v_r[k]    <= {v_r[k-1][VW-3:0], 2'b00};
        rem_r[k]  <= ge ? diff[RW+1:0] : tr[RW+1:0];
        root_r[k] <= {root_r[k-1][RW-2:0], ge};
      end
    end
  end

  assign root = root_r[RW];

endmodule

// ===== rtl/core/lbps_cordic.sv =====
// Pipelined vectoring CORDIC giving the centre link angle folded into a half turn.
// Depends on lbps_pkg.
module lbps_cordic (
  input  logic               clk,
  input  logic               en,
  input  logic signed [16:0] dx,
  input  logic signed [16:0] dy,
  output logic [13:0]        link
);
  import lbps_pkg::*;

  localparam int unsigned STEPS = 16;

  logic signed [25:0] x_r  [0:STEPS];
  logic signed [25:0] y_r  [0:STEPS];
  logic signed [24:0] z_r  [0:STEPS];
  link_case_t         lc_r [0:STEPS];
  logic [13:0]        link_r;

  logic signed [16:0] fdx;
  logic signed [16:0] fdy;
  logic signed [16:0] mag;
  link_case_t         lc_nxt;

  always_comb begin
    fdx = dy[16] ? -dx : dx;
    fdy = dy[16] ? -dy : dy;
    mag = fdx[16] ? -fdx : fdx;
    if (fdy == '0) begin
      lc_nxt = fdx[16] ? LINK_HALF : LINK_ZERO;
    end else if (fdx == '0) begin
      lc_nxt = LINK_QUARTER;
    end else if (!fdx[16]) begin
      lc_nxt = LINK_DIRECT;
    end else begin
      lc_nxt = LINK_MIRROR;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0]  <= $signed({4'b0000, mag[15:0], 6'b000000});
      y_r[0]  <= $signed({4'b0000, fdy[15:0], 6'b000000});
      z_r[0]  <= '0;
      lc_r[0] <= lc_nxt;
    end
  end

  for (genvar i = 0; i < STEPS; i++) begin : g_rot
    logic signed [25:0] sx;
    logic signed [25:0] sy;

    assign sx = shr_sym(x_r[i], i);
    assign sy = shr_sym(y_r[i], i);

    always_ff @(posedge clk) begin
      if (en) begin
        if (!y_r[i][25]) begin
          x_r[i+1] <= x_r[i] + sy;
          y_r[i+1] <= y_r[i] - sx;
          z_r[i+1] <= z_r[i] + atan_step(i);
        end else begin
          x_r[i+1] <= x_r[i] - sy;
          y_r[i+1] <= y_r[i] + sx;
          z_r[i+1] <= z_r[i] - atan_step(i);
        end
        lc_r[i+1] <= lc_r[i];
      end
    end
  end

  logic signed [24:0] zc;
  logic [23:0]        zr;
  logic [13:0]        qa;
  logic [13:0]        link_nxt;

  always_comb begin
    if (z_r[STEPS] < 0) begin
      zc = '0;
    end else if (z_r[STEPS] > Z_MAX) begin
      zc = Z_MAX;
    end else begin
      zc = z_r[STEPS];
    end
    zr = zc[23:0] + 24'd512;
    qa = zr[23:10];
    case (lc_r[STEPS])
      LINK_ZERO:    link_nxt = '0;
      LINK_HALF:    link_nxt = HALF_TURN;
      LINK_QUARTER: link_nxt = QUARTER_TURN;
      LINK_DIRECT:  link_nxt = qa;
      LINK_MIRROR:  link_nxt = HALF_TURN - qa;
      default:      link_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      link_r <= link_nxt;
    end
  end

  assign link = link_r;

endmodule

// ===== rtl/core/light_bar_pair_scorer.sv =====
// Top level of the light bar pair scorer: configuration, alignment and decision stages.
// Depends on lbps_pkg, lbps_dly, lbps_div, lbps_isqrt, lbps_cordic and the defines header.
//
//   Channel   Direction  Handshake          Payload
//   in_*      input      in_valid/in_stall  two bars: centre, width, height, raw angle
//   out_*     output     out_valid/out_stall  verdict, plate geometry, badness
//   cfg_*     input      cfg_we             register index and write data
//
// One transaction enters per cycle while in_stall is low.
// The depth is set by the chain of ratio dividers followed by the score dividers.
// The whole pipeline freezes while a finished result is held by out_stall.
// Reset clears the valid bits and loads the default limits; data registers are not reset.
`include "light_bar_pair_scorer_defines.svh"

module light_bar_pair_scorer (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [15:0]           in_first_center_x,
  input  logic [15:0]           in_first_center_y,
  input  logic [15:0]           in_first_width,
  input  logic [15:0]           in_first_height,
  input  logic signed [13:0]    in_first_raw_angle,
  input  logic [15:0]           in_second_center_x,
  input  logic [15:0]           in_second_center_y,
  input  logic [15:0]           in_second_width,
  input  logic [15:0]           in_second_height,
  input  logic signed [13:0]    in_second_raw_angle,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic                  out_accepted,
  output logic [2:0]            out_reject_cause,
  output logic [16:0]           out_plate_width,
  output logic [19:0]           out_plate_height,
  output logic [13:0]           out_plate_angle,
  output logic                  out_big_plate,
  output logic [17:0]           out_badness,
  input  logic                  cfg_we,
  input  logic [2:0]            cfg_index,
  input  logic [14:0]           cfg_wdata
);
  import lbps_pkg::*;

  localparam int unsigned OUT_STAGE = 48;

  // Configuration registers.
  logic [14:0] max_area_r;
  logic [14:0] max_side_r;
  logic [14:0] max_par_r;
  logic [14:0] max_miss_r;
  logic [10:0] min_asp_r;
  logic [10:0] max_asp_r;
  logic [10:0] large_asp_r;
  logic [11:0] hscale_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_area_r  <= 15'd1536;
      max_side_r  <= 15'd1024;
      max_par_r   <= 15'd960;
      max_miss_r  <= 15'd960;
      min_asp_r   <= 11'd69;
      max_asp_r   <= 11'd707;
      large_asp_r <= 11'd374;
      hscale_r    <= 12'd596;
    end else if (cfg_we) begin
      case (cfg_idx_t'(cfg_index))
        REG_MAX_AREA_RATIO_DEV: max_area_r  <= cfg_wdata;
        REG_MAX_SIDE_RATIO_DEV: max_side_r  <= cfg_wdata;
        REG_MAX_PARALLEL_ERROR: max_par_r   <= cfg_wdata;
        REG_MAX_LINK_MISS:      max_miss_r  <= cfg_wdata;
        REG_MIN_PLATE_ASPECT:   min_asp_r   <= cfg_wdata[10:0];
        REG_MAX_PLATE_ASPECT:   max_asp_r   <= cfg_wdata[10:0];
        REG_LARGE_PLATE_ASPECT: large_asp_r <= cfg_wdata[10:0];
        REG_HEIGHT_SCALE:       hscale_r    <= cfg_wdata[11:0];
        default: ;
      endcase
    end
  end

  // Pipeline control.
  logic              adv;
  logic [OUT_STAGE:0] vld_r;

  assign adv      = !(vld_r[OUT_STAGE] && out_stall);
  assign in_stall = !adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (adv) begin
      vld_r <= {vld_r[OUT_STAGE-1:0], in_valid};
    end
  end

  // First stage: sides, angles, areas and squared offsets.
  logic [15:0]        s1_nxt, l1_nxt, s2_nxt, l2_nxt;
  logic signed [16:0] dx_nxt, dy_nxt;
  logic signed [33:0] dxsq_nxt, dysq_nxt;

  always_comb begin
    s1_nxt   = (in_first_width < in_first_height) ? in_first_width : in_first_height;
    l1_nxt   = (in_first_width < in_first_height) ? in_first_height : in_first_width;
    s2_nxt   = (in_second_width < in_second_height) ? in_second_width : in_second_height;
    l2_nxt   = (in_second_width < in_second_height) ? in_second_height : in_second_width;
    dx_nxt   = $signed({1'b0, in_first_center_x}) - $signed({1'b0, in_second_center_x});
    dy_nxt   = $signed({1'b0, in_first_center_y}) - $signed({1'b0, in_second_center_y});
    dxsq_nxt = 34'(dx_nxt) * 34'(dx_nxt);
    dysq_nxt = 34'(dy_nxt) * 34'(dy_nxt);
  end

  logic [31:0]        area1_r, area2_r;
  logic [15:0]        s1_r, l1_r, s2_r, l2_r;
  logic [13:0]        a1_r, a2_r;
  logic signed [16:0] dx_r, dy_r;
  logic [31:0]        dxsq_r, dysq_r;
  logic [16:0]        lsum_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      area1_r <= 32'(in_first_width) * 32'(in_first_height);
      area2_r <= 32'(in_second_width) * 32'(in_second_height);
      s1_r    <= s1_nxt;
      l1_r    <= l1_nxt;
      s2_r    <= s2_nxt;
      l2_r    <= l2_nxt;
      a1_r    <= real_angle(in_first_width, in_first_height, in_first_raw_angle);
      a2_r    <= real_angle(in_second_width, in_second_height, in_second_raw_angle);
      dx_r    <= dx_nxt;
      dy_r    <= dy_nxt;
      dxsq_r  <= dxsq_nxt[31:0];
      dysq_r  <= dysq_nxt[31:0];
      lsum_r  <= 17'(l1_nxt) + 17'(l2_nxt);
    end
  end

  // Second stage: plate height and bar angle difference.
  logic [28:0]        ph_prod;
  logic signed [14:0] adiff, amag, aoff, aabs, dis_full;
  logic [19:0]        ph_r;
  logic [12:0]        dis_r;
  logic [13:0]        a2p_r;

  always_comb begin
    ph_prod  = 29'(lsum_r) * 29'(hscale_r);
    adiff    = $signed({1'b0, a1_r}) - $signed({1'b0, a2_r});
    amag     = adiff[14] ? -adiff : adiff;
    aoff     = amag - $signed({1'b0, QUARTER_TURN});
    aabs     = aoff[14] ? -aoff : aoff;
    dis_full = $signed({1'b0, QUARTER_TURN}) - aabs;
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ph_r  <= ph_prod[28:9];
      dis_r <= dis_full[12:0];
      a2p_r <= a2_r;
    end
  end

  // Ratio dividers.
  logic [24:0] q_area, q_short, q_long;
  logic        s_area, s_short, s_long;

  lbps_div #(.NW(40), .DW(32), .QW(25)) u_div_area (
    .clk(clk), .en(adv), .num({area1_r, 8'h00}), .den(area2_r),
    .quo(q_area), .sat(s_area)
  );

  lbps_div #(.NW(26), .DW(16), .QW(25)) u_div_short (
    .clk(clk), .en(adv), .num({2'b00, s1_r, 8'h00}), .den(s2_r),
    .quo(q_short), .sat(s_short)
  );

  lbps_div #(.NW(26), .DW(16), .QW(25)) u_div_long (
    .clk(clk), .en(adv), .num({2'b00, l1_r, 8'h00}), .den(l2_r),
    .quo(q_long), .sat(s_long)
  );

  function automatic logic [23:0] ratio_dev(input logic [24:0] q, input logic sat);
    logic [24:0] d;
    d = (q >= 25'd256) ? (q - 25'd256) : (25'd256 - q);
    if (sat || (d > 25'(DEV_SAT))) begin
      return DEV_SAT;
    end
    return d[23:0];
  endfunction

  logic [23:0] sr_r, wr_r, hr_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_r <= ratio_dev(q_area, s_area);
      wr_r <= ratio_dev(q_short, s_short);
      hr_r <= ratio_dev(q_long, s_long);
    end
  end

  // Plate width and link angle.
  logic [16:0] pw;
  logic [13:0] link;
  logic [19:0] ph_d;

  lbps_isqrt u_isqrt (
    .clk(clk), .en(adv), .sq_a(dxsq_r), .sq_b(dysq_r), .root(pw)
  );

  lbps_cordic u_cordic (
    .clk(clk), .en(adv), .dx(dx_r), .dy(dy_r), .link(link)
  );

  lbps_dly #(.W(20), .N(17)) u_dly_ph (
    .clk(clk), .en(adv), .din(ph_r), .dout(ph_d)
  );

  logic [23:0] q_asp;
  logic        s_asp;

  lbps_div #(.NW(25), .DW(20), .QW(24)) u_div_asp (
    .clk(clk), .en(adv), .num({pw, 8'h00}), .den(ph_d),
    .quo(q_asp), .sat(s_asp)
  );

  // Alignment of side data with the score dividers.
  logic [13:0] a2_m, a2_f;
  logic [12:0] dis_m, dis_f;
  logic [16:0] pw_f;
  logic [19:0] ph_f;
  logic [13:0] link_f;
  logic [23:0] q_asp_f;
  logic        s_asp_f;
  logic [23:0] sr_f, wr_f, hr_f;

  lbps_dly #(.W(27), .N(26)) u_dly_ang_a (
    .clk(clk), .en(adv), .din({a2p_r, dis_r}), .dout({a2_m, dis_m})
  );

  lbps_dly #(.W(27), .N(19)) u_dly_ang_b (
    .clk(clk), .en(adv), .din({a2_m, dis_m}), .dout({a2_f, dis_f})
  );

  lbps_dly #(.W(51), .N(28)) u_dly_geo (
    .clk(clk), .en(adv), .din({pw, ph_d, link}), .dout({pw_f, ph_f, link_f})
  );

  lbps_dly #(.W(25), .N(3)) u_dly_asp (
    .clk(clk), .en(adv), .din({q_asp, s_asp}), .dout({q_asp_f, s_asp_f})
  );

  lbps_dly #(.W(72), .N(19)) u_dly_dev (
    .clk(clk), .en(adv), .din({sr_r, wr_r, hr_r}), .dout({sr_f, wr_f, hr_f})
  );

  // Score dividers.
  logic [17:0] t_sr, t_wr, t_hr, t_dis;
  logic        o_sr, o_wr, o_hr, o_dis;

  lbps_div #(.NW(32), .DW(15), .QW(18)) u_div_tsr (
    .clk(clk), .en(adv), .num({sr_r, 8'h00}), .den(max_area_r),
    .quo(t_sr), .sat(o_sr)
  );

  lbps_div #(.NW(32), .DW(15), .QW(18)) u_div_twr (
    .clk(clk), .en(adv), .num({wr_r, 8'h00}), .den(max_side_r),
    .quo(t_wr), .sat(o_wr)
  );

  lbps_div #(.NW(32), .DW(15), .QW(18)) u_div_thr (
    .clk(clk), .en(adv), .num({hr_r, 8'h00}), .den(max_side_r),
    .quo(t_hr), .sat(o_hr)
  );

  lbps_div #(.NW(32), .DW(15), .QW(18)) u_div_tdis (
    .clk(clk), .en(adv), .num({11'd0, dis_m, 8'h00}), .den(max_par_r),
    .quo(t_dis), .sat(o_dis)
  );

  // Decision stage one: tests, link miss and partial score.
  logic [23:0]        asp;
  logic signed [15:0] md, mabs, moff, mfin;
  logic [17:0]        u_sr, u_wr, u_hr, u_dis;
  logic               tsat_nxt;

  always_comb begin
    asp  = s_asp_f ? DEV_SAT : q_asp_f;
    md   = $signed({2'b00, a2_f}) - $signed({2'b00, link_f});
    mabs = md[15] ? -md : md;
    moff = $signed({2'b00, QUARTER_TURN}) - mabs;
    mfin = moff[15] ? -moff : moff;
    u_sr  = (max_area_r == '0) ? '0 : t_sr;
    u_wr  = (max_side_r == '0) ? '0 : t_wr;
    u_hr  = (max_side_r == '0) ? '0 : t_hr;
    u_dis = (max_par_r == '0) ? '0 : t_dis;
    tsat_nxt = ((max_area_r != '0) && o_sr) || ((max_side_r != '0) && (o_wr || o_hr)) ||
               ((max_par_r != '0) && o_dis);
  end

  logic [12:0] miss_r;
  logic        size_fail_r, par_fail_r, asp_fail_r, large_r, tsat_r;
  logic [19:0] tsum_r;
  logic [16:0] pw_g_r;
  logic [19:0] ph_g_r;
  logic [13:0] a2_g_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      miss_r      <= mfin[12:0];
      size_fail_r <= (sr_f > 24'(max_area_r)) || (wr_f > 24'(max_side_r)) ||
                     (hr_f > 24'(max_side_r));
      par_fail_r  <= 15'(dis_f) > max_par_r;
      asp_fail_r  <= (asp < 24'(min_asp_r)) || (asp > 24'(max_asp_r));
      large_r     <= asp > 24'(large_asp_r);
      tsum_r      <= 20'(u_sr) + 20'(u_wr) + 20'(u_hr) + 20'(u_dis);
      tsat_r      <= tsat_nxt;
      pw_g_r      <= pw_f;
      ph_g_r      <= ph_f;
      a2_g_r      <= a2_f;
    end
  end

  // Decision stage two: reject cause and final score.
  cause_t      cause;
  logic [20:0] total;
  logic [17:0] bad;

  always_comb begin
    if (size_fail_r) begin
      cause = CAUSE_SIZE;
    end else if (par_fail_r) begin
      cause = CAUSE_PARALLEL;
    end else if (asp_fail_r) begin
      cause = CAUSE_ASPECT;
    end else if (15'(miss_r) > max_miss_r) begin
      cause = CAUSE_LINK;
    end else begin
      cause = CAUSE_NONE;
    end
    total = 21'(tsum_r) + 21'({miss_r, 2'b00});
    if (cause != CAUSE_NONE) begin
      bad = '0;
    end else if (tsat_r || (total > 21'(BAD_SAT))) begin
      bad = BAD_SAT;
    end else begin
      bad = total[17:0];
    end
  end

  logic        acc_out_r, large_out_r;
  logic [2:0]  cause_out_r;
  logic [16:0] pw_out_r;
  logic [19:0] ph_out_r;
  logic [13:0] ang_out_r;
  logic [17:0] bad_out_r;

  always_ff @(posedge clk) begin
    if (adv) begin
      acc_out_r   <= cause == CAUSE_NONE;
      cause_out_r <= cause;
      pw_out_r    <= pw_g_r;
      ph_out_r    <= ph_g_r;
      ang_out_r   <= a2_g_r;
      large_out_r <= (cause == CAUSE_NONE) && large_r;
      bad_out_r   <= bad;
    end
  end

  assign out_valid        = vld_r[OUT_STAGE];
  assign out_accepted     = acc_out_r;
  assign out_reject_cause = cause_out_r;
  assign out_plate_width  = pw_out_r;
  assign out_plate_height = ph_out_r;
  assign out_plate_angle  = ang_out_r;
  assign out_big_plate    = large_out_r;
  assign out_badness      = bad_out_r;

  `LBPS_ASSERT_SAME(a_reject_clean, out_valid && !out_accepted, (out_badness == '0) && !out_big_plate, "Rejected transaction carries a score or large flag.")
  `LBPS_ASSERT_SAME(a_accept_code, out_valid, out_accepted == (out_reject_cause == CAUSE_NONE), "Accept flag disagrees with the reject cause.")
  `LBPS_ASSERT_SAME(a_angle_range, out_valid, out_plate_angle < HALF_TURN, "Plate angle outside a half turn.")
  `LBPS_ASSERT_NEXT(a_freeze, out_valid && out_stall, $stable(vld_r), "Pipeline moved while the result was held.")

endmodule
